// File: hw/rtl/bba_pkg.sv
package bba_pkg;

    // Field widths
    localparam int CNT_W     = 13;
    localparam int IDX_W     = 12;
    localparam int ADDR_W    = 24;
    localparam int ST_W      = 2;
    localparam int CFG_IDX_W = 2;

    // Largest window a 13-bit count register can describe
    localparam int MAX_BLOCKS = (1 << CNT_W) - 1;

    // Bitmap organisation; WORD_BITS must be a power of two
    localparam int WORD_BITS   = 32;
    localparam int WORD_LG     = $clog2(WORD_BITS);
    localparam int BLOCK_BYTES = 4096;

    localparam int NUM_BLOCKS_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;

    // Configuration register reset values
    localparam logic [CNT_W-1:0] BLOCK_COUNT_RST = CNT_W'(4096);
    localparam logic [CNT_W-1:0] RESERVED_RST    = CNT_W'(1024);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RESERVED    = CFG_IDX_W'(1);

    // Request actions
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    // Result status codes
    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NOFREE   = 2'd1;
    localparam logic [ST_W-1:0] ST_BADIDX   = 2'd2;
    localparam logic [ST_W-1:0] ST_NOTALLOC = 2'd3;

    // Classified command kinds
    localparam logic [1:0] CMD_ALLOC = 2'd0;
    localparam logic [1:0] CMD_FREE  = 2'd1;
    localparam logic [1:0] CMD_BAD   = 2'd2;

    typedef struct packed {
        logic [CNT_W-1:0] base;
        logic [CNT_W-1:0] top;
    } window_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [CNT_W-1:0] index;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

// File: hw/rtl/bba_channels.sv
interface blk_req_if;
    import bba_pkg::*;

    logic             valid;
    logic             ready;
    logic             action;
    logic [IDX_W-1:0] block_index;

    modport source (output valid, action, block_index, input ready);
    modport sink   (input valid, action, block_index, output ready);
endinterface

interface blk_rsp_if;
    import bba_pkg::*;

    logic              valid;
    logic              ready;
    logic [ST_W-1:0]   status;
    logic [IDX_W-1:0]  granted_index;
    logic [ADDR_W-1:0] granted_address;
    logic [CNT_W-1:0]  free_blocks;

    modport source (output valid, status, granted_index, granted_address, free_blocks,
                    input ready);
    modport sink   (input valid, status, granted_index, granted_address, free_blocks,
                    output ready);
endinterface

interface blk_cfg_if;
    import bba_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CNT_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hw/rtl/bba_queue.sv
module bba_queue #(
    parameter int DEPTH = bba_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bba_pkg::cmd_t    push_cmd,
    input  logic             pop,
    output bba_pkg::cmd_t    pop_cmd,
    output bba_pkg::q_stat_t stat
);
    import bba_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    cmd_t          entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   count_reg;
    logic          do_push;
    logic          do_pop;

    assign stat.full  = (count_reg == (PW+1)'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    // Store the incoming command
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/bba_front.sv
module bba_front (
    blk_req_if.sink          req,
    input  bba_pkg::window_t win,
    input  bba_pkg::q_stat_t q_stat,
    output logic             push,
    output bba_pkg::cmd_t    cmd
);
    import bba_pkg::*;

    logic [CNT_W-1:0] idx_ext;
    logic             out_of_window;

    assign req.ready     = !q_stat.full;
    assign push          = req.valid && !q_stat.full;
    assign idx_ext       = CNT_W'(req.block_index);
    assign out_of_window = (idx_ext < win.base) || (idx_ext >= win.top);

    // Classify the request; reject frees outside the allocatable window here
    always_comb
    begin
        cmd.index = idx_ext;
        if (req.action == ACT_ALLOC)
        begin
            cmd.kind = CMD_ALLOC;
        end
        else if (out_of_window)
        begin
            cmd.kind = CMD_BAD;
        end
        else
        begin
            cmd.kind = CMD_FREE;
        end
    end

endmodule

// File: hw/rtl/bba_back.sv
module bba_back #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  bba_pkg::window_t win,
    input  bba_pkg::q_stat_t q_stat,
    input  bba_pkg::cmd_t    q_cmd,
    output logic             q_pop,
    blk_rsp_if.source        rsp
);
    import bba_pkg::*;

    localparam int CAP   = (NUM_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : NUM_BLOCKS;
    localparam int WORDS = (CAP + WORD_BITS - 1) / WORD_BITS;
    localparam int AW    = $clog2(WORDS);
    localparam int BB_W  = $clog2(BLOCK_BYTES + 1);
    localparam int PRD_W = CNT_W + BB_W;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_SCAN     = 2'd1;
    localparam logic [1:0] S_FREE_CHK = 2'd2;
    localparam logic [1:0] S_POST     = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;

    // Bitmap storage with a per-word valid bit standing in for the reset clear
    logic [WORD_BITS-1:0] bitmap_reg [WORDS];
    logic [WORDS-1:0]     word_vld_reg;
    logic [WORD_BITS-1:0] rd_data_reg;
    logic                 rd_vld_bit_reg;
    logic [AW-1:0]        chk_addr_reg;
    logic                 chk_vld_reg;

    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [WORD_BITS-1:0] wr_data;

    logic [AW:0]          scan_addr_reg;
    logic [AW:0]          scan_addr_next;
    logic [CNT_W-1:0]     cmd_index_reg;
    logic [CNT_W-1:0]     cmd_index_next;
    logic [ST_W-1:0]      res_status_reg;
    logic [ST_W-1:0]      res_status_next;
    logic [CNT_W-1:0]     res_index_reg;
    logic [CNT_W-1:0]     res_index_next;
    logic [CNT_W-1:0]     used_count_reg;
    logic [CNT_W-1:0]     used_count_next;

    logic                 out_valid_reg;
    logic [ST_W-1:0]      out_status_reg;
    logic [IDX_W-1:0]     out_index_reg;
    logic [ADDR_W-1:0]    out_addr_reg;
    logic [CNT_W-1:0]     out_free_reg;
    logic                 out_load;

    logic [CNT_W-1:0]     top_m1;
    logic [AW:0]          first_word;
    logic [AW:0]          last_word;
    logic [WORD_LG-1:0]   base_lo;
    logic [WORD_LG-1:0]   last_lo;
    logic                 at_first;
    logic                 at_last;
    logic [WORD_BITS-1:0] word_d;
    logic [WORD_BITS-1:0] allow;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_LG-1:0]   pick;
    logic                 found;
    logic [CNT_W-1:0]     grant_idx;
    logic [WORD_LG-1:0]   free_pos;
    logic                 free_bit_set;
    logic                 issue;

    logic [CNT_W-1:0]     span;
    logic [CNT_W-1:0]     free_now;
    logic [PRD_W-1:0]     addr_prod;

    // Window bounds in words and bit positions
    assign top_m1     = win.top - 1'b1;
    assign first_word = (AW+1)'(win.base >> WORD_LG);
    assign last_word  = (AW+1)'(top_m1 >> WORD_LG);
    assign base_lo    = win.base[WORD_LG-1:0];
    assign last_lo    = top_m1[WORD_LG-1:0];

    // Examine the word returned by the previous read
    assign word_d   = rd_vld_bit_reg ? rd_data_reg : '0;
    assign at_first = ({1'b0, chk_addr_reg} == first_word);
    assign at_last  = ({1'b0, chk_addr_reg} == last_word);

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            allow[b] = !(at_first && (WORD_LG'(b) < base_lo))
                    && !(at_last && (WORD_LG'(b) > last_lo));
        end
    end

    assign free_bits = ~word_d & allow;
    assign found     = |free_bits;

    // Lowest free bit of the word
    always_comb
    begin
        pick = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_bits[b])
            begin
                pick = WORD_LG'(b);
            end
        end
    end

    assign grant_idx    = CNT_W'({chk_addr_reg, pick});
    assign free_pos     = cmd_index_reg[WORD_LG-1:0];
    assign free_bit_set = word_d[free_pos];
    assign issue        = (scan_addr_reg <= last_word);

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        scan_addr_next  = scan_addr_reg;
        cmd_index_next  = cmd_index_reg;
        res_status_next = res_status_reg;
        res_index_next  = res_index_reg;
        used_count_next = used_count_reg;
        q_pop           = 1'b0;
        rd_en           = 1'b0;
        rd_addr         = scan_addr_reg[AW-1:0];
        wr_en           = 1'b0;
        wr_data         = word_d | (WORD_BITS'(1) << pick);
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    q_pop          = 1'b1;
                    cmd_index_next = q_cmd.index;
                    res_index_next = '0;
                    unique case (q_cmd.kind)
                        CMD_ALLOC:
                        begin
                            if (win.base == win.top)
                            begin
                                res_status_next = ST_NOFREE;
                                state_next      = S_POST;
                            end
                            else
                            begin
                                scan_addr_next = first_word;
                                state_next     = S_SCAN;
                            end
                        end
                        CMD_FREE:
                        begin
                            rd_en      = 1'b1;
                            rd_addr    = AW'(q_cmd.index >> WORD_LG);
                            state_next = S_FREE_CHK;
                        end
                        default:
                        begin
                            res_status_next = ST_BADIDX;
                            state_next      = S_POST;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    rd_en          = 1'b1;
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (found)
                    begin
                        wr_en           = 1'b1;
                        used_count_next = used_count_reg + 1'b1;
                        res_status_next = ST_OK;
                        res_index_next  = grant_idx;
                        state_next      = S_POST;
                    end
                    else if (at_last)
                    begin
                        res_status_next = ST_NOFREE;
                        state_next      = S_POST;
                    end
                end
            end
            S_FREE_CHK:
            begin
                wr_data = word_d & ~(WORD_BITS'(1) << free_pos);
                if (free_bit_set)
                begin
                    wr_en           = 1'b1;
                    used_count_next = (used_count_reg != '0) ? used_count_reg - 1'b1
                                                             : used_count_reg;
                    res_status_next = ST_OK;
                    res_index_next  = cmd_index_reg;
                end
                else
                begin
                    res_status_next = ST_NOTALLOC;
                end
                state_next = S_POST;
            end
            S_POST:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Free count and byte address of the finished request
    assign span      = win.top - win.base;
    assign free_now  = (span > used_count_reg) ? span - used_count_reg : '0;
    assign addr_prod = PRD_W'(res_index_reg) * PRD_W'(BLOCK_BYTES);

    // Bitmap write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_reg[chk_addr_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg    <= bitmap_reg[rd_addr];
            rd_vld_bit_reg <= word_vld_reg[rd_addr];
            chk_addr_reg   <= rd_addr;
        end
    end

    // Hold the result payload for the receiver
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg[IDX_W-1:0];
            out_addr_reg   <= ADDR_W'(addr_prod);
            out_free_reg   <= free_now;
        end
        scan_addr_reg  <= scan_addr_next;
        cmd_index_reg  <= cmd_index_next;
        res_status_reg <= res_status_next;
        res_index_reg  <= res_index_next;
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            word_vld_reg   <= '0;
            chk_vld_reg    <= 1'b0;
            used_count_reg <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            chk_vld_reg    <= rd_en;
            used_count_reg <= used_count_next;
            if (wr_en)
            begin
                word_vld_reg[chk_addr_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp.valid           = out_valid_reg;
    assign rsp.status          = out_status_reg;
    assign rsp.granted_index   = out_index_reg;
    assign rsp.granted_address = out_addr_reg;
    assign rsp.free_blocks     = out_free_reg;

endmodule

// File: hw/rtl/bitmap_block_allocator.sv
// First-fit block allocator over a used-bit bitmap.
// Channels: req carries allocate/free requests (action, block_index), rsp returns one
// result per request (status, granted_index, granted_address, free_blocks) in request
// order, cfg writes block_count (index 0) and reserved_blocks (index 1); cfg is always
// ready; the user must write cfg only while no request is outstanding (not checked).
// A front stage classifies each request (frees outside the window are rejected there)
// and queues it; a back stage carries it out against the bitmap memory.
// An allocate reads bitmap words from the bottom of the window up to the first word
// holding a free block (at most 128 words at the default size); the single memory
// read port delivers one word per cycle. One request is executed at a time; up to two
// more wait in the queue, so requests keep being accepted while a result is pending.
// Reset clears all used bits through per-word valid flags, zeroes the used count and
// loads block_count 4096 and reserved_blocks 1024; no clearing pass is needed.
// When the receiver stalls, the result is held in the output register, the back stage
// holds its next finished result, and req.ready drops once the queue fills.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = bba_pkg::NUM_BLOCKS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    blk_cfg_if.sink   cfg,
    blk_req_if.sink   req,
    blk_rsp_if.source rsp
);
    import bba_pkg::*;

    localparam int CAP = (NUM_BLOCKS > MAX_BLOCKS) ? MAX_BLOCKS : NUM_BLOCKS;

    logic [CNT_W-1:0] blk_count_reg;
    logic [CNT_W-1:0] rsv_reg;
    logic [CNT_W-1:0] top_eff;
    window_t          win;
    q_stat_t          q_stat;
    logic             q_push;
    logic             q_pop;
    cmd_t             push_cmd;
    cmd_t             pop_cmd;

    assign cfg.ready = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blk_count_reg <= BLOCK_COUNT_RST;
            rsv_reg       <= RESERVED_RST;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_BLOCK_COUNT: blk_count_reg <= cfg.data;
                CFG_RESERVED:    rsv_reg       <= cfg.data;
                default:         ;
            endcase
        end
    end

    // Clamp the window to the storage present
    assign top_eff  = (blk_count_reg > CNT_W'(CAP)) ? CNT_W'(CAP) : blk_count_reg;
    assign win.top  = top_eff;
    assign win.base = (rsv_reg > top_eff) ? top_eff : rsv_reg;

    bba_front u_front (
        .req    (req),
        .win    (win),
        .q_stat (q_stat),
        .push   (q_push),
        .cmd    (push_cmd)
    );

    bba_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .pop      (q_pop),
        .pop_cmd  (pop_cmd),
        .stat     (q_stat)
    );

    bba_back #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .win    (win),
        .q_stat (q_stat),
        .q_cmd  (pop_cmd),
        .q_pop  (q_pop),
        .rsp    (rsp)
    );

    // The front never pushes into a full queue
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // Queue occupancy flags stay consistent
    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue reports full and empty together");

    // A failed request carries no block
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != ST_OK)) |->
            ((rsp.granted_index == '0) && (rsp.granted_address == '0)))
        else $error("failed result carries a block");

endmodule
